// ===== rtl/dotta_pkg.sv =====
package dotta_pkg;

  // Fixed counter widths of the debounce, prescaler, seconds and blink counters.
  localparam int unsigned StableW  = 6;
  localparam int unsigned MilliW   = 10;
  localparam int unsigned SecondsW = 7;
  localparam int unsigned BlinkW   = 8;
  localparam int unsigned SegW     = 7;

  // Largest value the two-digit display can show.
  localparam logic [SecondsW-1:0] DisplayMax = SecondsW'(99);

  // Reset value of the alarm threshold register.
  localparam logic [SecondsW-1:0] ThresholdReset = SecondsW'(10);

  typedef logic [SegW-1:0] seg_t;

  // Active-low seven-segment codes for the decimal digits.
  localparam seg_t SegCode [10] = '{
    7'h40, 7'h79, 7'h24, 7'h30, 7'h19, 7'h12, 7'h02, 7'h78, 7'h00, 7'h18
  };

  // Tens digit of a value up to 99, by multiplying with 205/2048.
  function automatic logic [3:0] tens_of(input logic [SecondsW-1:0] value);
    logic [14:0] prod;
    prod = 15'(value) * 15'd205;
    return prod[14:11];
  endfunction

endpackage

// ===== rtl/debounced_on_time_timer_alarm.sv =====
// Debounced on-time timer with threshold alarm.
//
// Input channel: one transfer per millisecond tick, carrying raw_switch_i.
// A transfer takes place at a rising clock edge with in_valid_i high and
// in_stall_o low. Output channel: one result transfer per input transfer,
// taken at an edge with out_valid_o high and out_stall_i low. The result
// carries the debounced level, the blinking alarm LED, the elapsed seconds,
// the timing flag, the stop event with its over-threshold verdict, and the
// active-low seven-segment codes of both digits.
//
// The result of a tick is loaded into the result register at the edge that
// takes the tick and is offered from there until the receiver takes it.
// The block takes one tick per cycle while no result waits on a stalled
// receiver; the counters and the digit decode all settle between the tick
// transfer and the result register. The block asks the sender to stall only
// while a result is held and the receiver stalls, so a new tick is still
// taken in the same cycle that the waiting result is taken.
//
// The configuration channel writes the alarm threshold (cfg_data_i) at an
// edge with cfg_valid_i and cfg_ready_o high; it is always ready. Reset
// clears all counters and levels, empties the result register and loads
// the threshold with ten seconds.
module debounced_on_time_timer_alarm #(
  parameter int unsigned DEBOUNCE_TICKS   = 50,
  parameter int unsigned TICKS_PER_SECOND = 1000,
  parameter int unsigned BLINK_TICKS      = 250,
  parameter int unsigned MAX_SECONDS      = 99
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Tick channel.
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               raw_switch_i,
  // Result channel.
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               switch_on_o,
  output logic                               alarm_led_o,
  output logic [dotta_pkg::SecondsW-1:0]     elapsed_seconds_o,
  output logic                               timing_active_o,
  output logic                               stop_event_o,
  output logic                               exceeded_at_stop_o,
  output logic [dotta_pkg::SegW-1:0]         segment_tens_o,
  output logic [dotta_pkg::SegW-1:0]         segment_ones_o,
  // Threshold write channel.
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [dotta_pkg::SecondsW-1:0]     cfg_data_i
);
  import dotta_pkg::*;

  localparam logic [StableW-1:0]  DebounceLim = StableW'(DEBOUNCE_TICKS);
  localparam logic [MilliW-1:0]   TickLim     = MilliW'(TICKS_PER_SECOND);
  localparam logic [BlinkW-1:0]   BlinkLim    = BlinkW'(BLINK_TICKS);
  localparam logic [SecondsW-1:0] SecondsMax  = SecondsW'(MAX_SECONDS);

  // Tick state.
  logic                accepted_q, accepted_d;
  logic [StableW-1:0]  stable_q, stable_d;
  logic [MilliW-1:0]   milli_q, milli_d;
  logic [SecondsW-1:0] seconds_q, seconds_d;
  logic                counting_q, counting_d;
  logic [BlinkW-1:0]   blink_cnt_q, blink_cnt_d;
  logic                blink_q, blink_d;
  logic [SecondsW-1:0] threshold_q;

  // Result register.
  logic                out_valid_q;
  logic                stop_q, stop_d;
  logic                over_q, over_d;
  seg_t                seg_tens_q, seg_tens_d;
  seg_t                seg_ones_q, seg_ones_d;

  logic                in_xfer;
  logic                out_busy;

  // The sender is held back only while a result waits on a stalled receiver.
  assign out_busy   = out_valid_q & out_stall_i;
  assign in_stall_o = out_busy;
  assign in_xfer    = in_valid_i & ~out_busy;
  assign cfg_ready_o = 1'b1;

  // Per tick: debounce and edge handling, then time counting, then blink, then digit decode.
  always_comb begin
    logic [StableW-1:0]  stable_inc;
    logic [MilliW-1:0]   milli_inc;
    logic [BlinkW-1:0]   blink_inc;
    logic [SecondsW-1:0] disp;
    logic [3:0]          tens;
    logic [3:0]          ones;
    logic [7:0]          tens_x10;

    accepted_d  = accepted_q;
    stable_d    = stable_q;
    milli_d     = milli_q;
    seconds_d   = seconds_q;
    counting_d  = counting_q;
    blink_cnt_d = blink_cnt_q;
    blink_d     = blink_q;
    stop_d      = 1'b0;
    over_d      = 1'b0;

    stable_inc = stable_q + StableW'(1);
    if (raw_switch_i != accepted_q) begin
      stable_d = stable_inc;
      if (stable_inc >= DebounceLim) begin
        accepted_d = raw_switch_i;
        stable_d   = '0;
        if (raw_switch_i) begin
          seconds_d  = '0;
          milli_d    = '0;
          counting_d = 1'b1;
        end else begin
          counting_d = 1'b0;
          stop_d     = 1'b1;
          over_d     = (seconds_q > threshold_q);
        end
      end
    end else begin
      stable_d = '0;
    end

    milli_inc = milli_d + MilliW'(1);
    if (counting_d) begin
      milli_d = milli_inc;
      if (milli_inc >= TickLim) begin
        milli_d = '0;
        if (seconds_d >= SecondsMax) begin
          seconds_d = SecondsMax;
        end else begin
          seconds_d = seconds_d + SecondsW'(1);
        end
      end
    end

    blink_inc = blink_cnt_q + BlinkW'(1);
    if (counting_d && (seconds_d > threshold_q)) begin
      blink_cnt_d = blink_inc;
      if (blink_inc >= BlinkLim) begin
        blink_cnt_d = '0;
        blink_d     = ~blink_q;
      end
    end else begin
      blink_cnt_d = '0;
      blink_d     = 1'b0;
    end

    disp       = (seconds_d > DisplayMax) ? DisplayMax : seconds_d;
    tens       = tens_of(disp);
    tens_x10   = {1'b0, tens, 3'b000} + {3'b000, tens, 1'b0};
    ones       = 4'(8'(disp) - tens_x10);
    seg_tens_d = SegCode[tens];
    seg_ones_d = SegCode[ones];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accepted_q  <= 1'b0;
      stable_q    <= '0;
      milli_q     <= '0;
      seconds_q   <= '0;
      counting_q  <= 1'b0;
      blink_cnt_q <= '0;
      blink_q     <= 1'b0;
      threshold_q <= ThresholdReset;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        threshold_q <= cfg_data_i;
      end
      if (in_xfer) begin
        accepted_q  <= accepted_d;
        stable_q    <= stable_d;
        milli_q     <= milli_d;
        seconds_q   <= seconds_d;
        counting_q  <= counting_d;
        blink_cnt_q <= blink_cnt_d;
        blink_q     <= blink_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result fields that are not copies of the tick state.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      stop_q     <= stop_d;
      over_q     <= over_d;
      seg_tens_q <= seg_tens_d;
      seg_ones_q <= seg_ones_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign switch_on_o        = accepted_q;
  assign alarm_led_o        = blink_q;
  assign elapsed_seconds_o  = seconds_q;
  assign timing_active_o    = counting_q;
  assign stop_event_o       = stop_q;
  assign exceeded_at_stop_o = over_q;
  assign segment_tens_o     = seg_tens_q;
  assign segment_ones_o     = seg_ones_q;

endmodule

// ===== rtl/dotta_checker.sv =====
module dotta_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_o,
  input  logic                           out_valid_o,
  input  logic                           out_stall_i,
  input  logic                           switch_on_o,
  input  logic                           alarm_led_o,
  input  logic [dotta_pkg::SecondsW-1:0] elapsed_seconds_o,
  input  logic                           timing_active_o,
  input  logic                           stop_event_o,
  input  logic                           exceeded_at_stop_o
);
  import dotta_pkg::*;

  // A stalled result keeps its payload.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(elapsed_seconds_o)
      && $stable(switch_on_o) && $stable(stop_event_o))
    else $error("stalled result changed");

  // A stop ends timing and reports the debounced level low.
  a_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stop_event_o |-> !timing_active_o && !switch_on_o)
    else $error("stop event while timing or switch on");

  // The verdict only comes with a stop.
  a_over: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && exceeded_at_stop_o |-> stop_event_o)
    else $error("exceeded flag without stop event");

  // The alarm is lit only while timing.
  a_alarm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && alarm_led_o |-> timing_active_o && switch_on_o)
    else $error("alarm lit while not timing");

  // Ticks are taken whenever no result waits on a stalled receiver.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

endmodule

bind debounced_on_time_timer_alarm dotta_checker u_dotta_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_stall_o         (in_stall_o),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .switch_on_o        (switch_on_o),
  .alarm_led_o        (alarm_led_o),
  .elapsed_seconds_o  (elapsed_seconds_o),
  .timing_active_o    (timing_active_o),
  .stop_event_o       (stop_event_o),
  .exceeded_at_stop_o (exceeded_at_stop_o)
);

// ===== tb/debounced_on_time_timer_alarm_tb.sv =====
`timescale 1ns / 1ps

module debounced_on_time_timer_alarm_tb;

  // The block runs with its default sizing, so the expected values here are
  // computed with the same numbers.
  localparam int unsigned DebounceTicks  = 50;
  localparam int unsigned TicksPerSecond = 1000;
  localparam int unsigned BlinkTicks     = 250;
  localparam int unsigned MaxSeconds     = 99;

  localparam int unsigned SecondsW = dotta_pkg::SecondsW;
  localparam int unsigned SegW     = dotta_pkg::SegW;

  // A run of this many cycles with no transfer on any channel means the block hung.
  localparam int unsigned QuietLimit = 2000;

  // Active-low seven-segment patterns for the digits zero to nine.
  localparam logic [SegW-1:0] DigitSegments [10] = '{
    7'h40, 7'h79, 7'h24, 7'h30, 7'h19, 7'h12, 7'h02, 7'h78, 7'h00, 7'h18
  };

  // Everything one result transfer carries.
  typedef struct packed {
    logic                switch_on;
    logic                alarm_led;
    logic [SecondsW-1:0] elapsed;
    logic                timing;
    logic                stop_event;
    logic                exceeded;
    logic [SegW-1:0]     tens;
    logic [SegW-1:0]     ones;
  } tick_result_t;

  // Tracks the timer as the block should see it and keeps the results that
  // accepted ticks still owe, oldest first.
  class on_time_predictor;
    tick_result_t                    owed_results[$];
    logic [SecondsW-1:0]             threshold;
    logic                            level;
    logic [dotta_pkg::StableW-1:0]   settle_count;
    logic [dotta_pkg::MilliW-1:0]    prescale;
    logic [SecondsW-1:0]             seconds;
    logic                            running;
    logic [dotta_pkg::BlinkW-1:0]    blink_timer;
    logic                            lamp;
    int unsigned                     mismatches;

    function new();
      threshold    = SecondsW'(10);
      level        = 1'b0;
      settle_count = '0;
      prescale     = '0;
      seconds      = '0;
      running      = 1'b0;
      blink_timer  = '0;
      lamp         = 1'b0;
      mismatches   = 0;
    endfunction

    function int unsigned pending();
      return owed_results.size();
    endfunction

    // Advances the timer by one accepted tick and records what it must report.
    function void take_tick(logic raw);
      tick_result_t r;
      int unsigned  shown;
      r = '0;
      if (raw != level) begin
        settle_count = settle_count + 1'b1;
        if (settle_count >= DebounceTicks) begin
          level        = raw;
          settle_count = '0;
          if (raw) begin
            seconds  = '0;
            prescale = '0;
            running  = 1'b1;
          end else begin
            // The verdict uses the count as it stood; no time is added on this tick.
            running      = 1'b0;
            r.stop_event = 1'b1;
            r.exceeded   = (seconds > threshold);
          end
        end
      end else begin
        settle_count = '0;
      end

      if (running) begin
        prescale = prescale + 1'b1;
        if (prescale >= TicksPerSecond) begin
          prescale = '0;
          if (seconds < MaxSeconds) seconds = seconds + 1'b1;
        end
      end

      if (running && seconds > threshold) begin
        blink_timer = blink_timer + 1'b1;
        if (blink_timer >= BlinkTicks) begin
          blink_timer = '0;
          lamp        = ~lamp;
        end
      end else begin
        blink_timer = '0;
        lamp        = 1'b0;
      end

      shown       = (seconds > 99) ? 99 : seconds;
      r.switch_on = level;
      r.alarm_led = lamp;
      r.elapsed   = seconds;
      r.timing    = running;
      r.tens      = DigitSegments[(shown / 10) % 10];
      r.ones      = DigitSegments[shown % 10];
      owed_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] %s mismatch: expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    // Compares one result transfer with the oldest owed result.
    function void check_result(tick_result_t got);
      tick_result_t want;
      if (owed_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] result transfer with no tick waiting for it", $time);
        return;
      end
      want = owed_results.pop_front();
      compare_field("switch_on", 8'(want.switch_on), 8'(got.switch_on));
      compare_field("alarm_led", 8'(want.alarm_led), 8'(got.alarm_led));
      compare_field("elapsed_seconds", 8'(want.elapsed), 8'(got.elapsed));
      compare_field("timing_active", 8'(want.timing), 8'(got.timing));
      compare_field("stop_event", 8'(want.stop_event), 8'(got.stop_event));
      compare_field("exceeded_at_stop", 8'(want.exceeded), 8'(got.exceeded));
      compare_field("segment_tens", 8'(want.tens), 8'(got.tens));
      compare_field("segment_ones", 8'(want.ones), 8'(got.ones));
    endfunction
  endclass

  logic                clk           = 1'b0;
  logic                rst_n         = 1'b0;
  logic                in_valid      = 1'b0;
  logic                in_stall;
  logic                raw_switch    = 1'b0;
  logic                out_valid;
  logic                out_stall     = 1'b0;
  logic                switch_on;
  logic                alarm_led;
  logic [SecondsW-1:0] elapsed_seconds;
  logic                timing_active;
  logic                stop_event;
  logic                exceeded_at_stop;
  logic [SegW-1:0]     segment_tens;
  logic [SegW-1:0]     segment_ones;
  logic                cfg_valid     = 1'b0;
  logic                cfg_ready;
  logic [SecondsW-1:0] cfg_data      = '0;

  on_time_predictor    timer_model;
  int unsigned         src_idle_pct  = 6;
  int unsigned         dst_stall_pct = 60;
  int unsigned         ticks_sent    = 0;
  int unsigned         quiet_cycles  = 0;

  always #10 clk = ~clk;

  debounced_on_time_timer_alarm #(
    .DEBOUNCE_TICKS  (DebounceTicks),
    .TICKS_PER_SECOND(TicksPerSecond),
    .BLINK_TICKS     (BlinkTicks),
    .MAX_SECONDS     (MaxSeconds)
  ) dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .raw_switch_i      (raw_switch),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .switch_on_o       (switch_on),
    .alarm_led_o       (alarm_led),
    .elapsed_seconds_o (elapsed_seconds),
    .timing_active_o   (timing_active),
    .stop_event_o      (stop_event),
    .exceeded_at_stop_o(exceeded_at_stop),
    .segment_tens_o    (segment_tens),
    .segment_ones_o    (segment_ones),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_data_i        (cfg_data)
  );

  // The receiver decides at every falling edge whether to hold off the next
  // result; the decision is independent of whether a result is on offer.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < dst_stall_pct);
  end

  // Every result transfer is checked against the oldest owed result. A result
  // from a tick can never be taken on the edge that took the tick, so the
  // order of this block and the driver within one edge does not matter.
  always @(posedge clk) begin : result_monitor
    tick_result_t got;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      got.switch_on  = switch_on;
      got.alarm_led  = alarm_led;
      got.elapsed    = elapsed_seconds;
      got.timing     = timing_active;
      got.stop_event = stop_event;
      got.exceeded   = exceeded_at_stop;
      got.tens       = segment_tens;
      got.ones       = segment_ones;
      timer_model.check_result(got);
    end
  end

  // Watchdog: any transfer on any channel proves the block is alive. A long
  // run of cycles with none means a hang, and the run is ended as a failure.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
        (cfg_valid && cfg_ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("debounced_on_time_timer_alarm verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one tick, starting at a falling edge. The sender may idle first,
  // then raises valid and holds the payload until the tick is transferred.
  // It returns at the falling edge after the transfer with valid still high,
  // so back-to-back ticks keep valid up without a glitch.
  task automatic send_tick(input logic level);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    raw_switch <= level;
    do @(posedge clk); while (in_stall !== 1'b0);
    timer_model.take_tick(level);
    ticks_sent++;
    @(negedge clk);
  endtask

  // Holds the switch at one level. With glitches enabled, the level is now and
  // then broken by a short opposite run, too short to pass the debouncer, which
  // must restart its settle count.
  task automatic hold_level(input logic level, input int unsigned ticks, input bit glitches);
    for (int unsigned k = 0; k < ticks; k++) begin
      if (glitches && $urandom_range(199) == 0)
        repeat ($urandom_range(1, DebounceTicks - 1)) send_tick(~level);
      send_tick(level);
    end
  endtask

  // Contact bounce: runs of random level, many of them right around the
  // debounce length so that both near misses and just-made edges happen.
  task automatic chatter(input int unsigned bursts);
    logic        level;
    int unsigned run;
    for (int unsigned b = 0; b < bursts; b++) begin
      level = 1'($urandom_range(1));
      if ($urandom_range(2) == 0)
        run = $urandom_range(DebounceTicks - 2, DebounceTicks + 1);
      else
        run = $urandom_range(1, 10);
      repeat (run) send_tick(level);
    end
  endtask

  // One use of the switch: some bounce, an on-time, then an off-time. Some
  // on-times sit right at the debounce limit; the rest are short presses.
  task automatic on_off_session();
    int unsigned pick;
    int unsigned on_ticks;
    pick = $urandom_range(99);
    if (pick < 30)
      on_ticks = $urandom_range(DebounceTicks - 3, DebounceTicks + 3);
    else
      on_ticks = $urandom_range(DebounceTicks + 1, 150);
    chatter($urandom_range(0, 3));
    hold_level(1'b1, on_ticks, 1'b1);
    hold_level(1'b0, $urandom_range(DebounceTicks - 3, 120), 1'b1);
  endtask

  // Stops offering ticks and waits until every owed result has arrived.
  task automatic quiesce();
    in_valid <= 1'b0;
    @(negedge clk);
    while (timer_model.pending() != 0) @(negedge clk);
  endtask

  // Threshold writes happen only with the block drained.
  task automatic write_threshold(input logic [SecondsW-1:0] value);
    quiesce();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    timer_model.threshold = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random sessions under one idle setting and one threshold, until about
  // the given number of ticks has gone in. Now and then the sender pauses
  // until the block has drained.
  task automatic run_phase(input int unsigned src_pct, input int unsigned dst_pct,
                           input logic [SecondsW-1:0] thr, input int unsigned budget);
    int unsigned start_ticks;
    src_idle_pct  = src_pct;
    dst_stall_pct = dst_pct;
    write_threshold(thr);
    start_ticks = ticks_sent;
    while (ticks_sent - start_ticks < budget) begin
      on_off_session();
      if ($urandom_range(7) == 0) quiesce();
    end
  endtask

  initial begin
    timer_model = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, with the threshold at its reset value of ten seconds.
    // A press one tick short of the debounce count must not register, and the
    // opposite tick after it must restart the settle count.
    hold_level(1'b0, 3, 1'b0);
    hold_level(1'b1, DebounceTicks - 1, 1'b0);
    hold_level(1'b0, 1, 1'b0);
    // A full press starts timing with the display at 00, and the release
    // stops it well under the threshold.
    hold_level(1'b1, DebounceTicks + 20, 1'b0);
    hold_level(1'b0, DebounceTicks, 1'b0);

    // A zero threshold: a press shorter than one second leaves the count at
    // zero, which is not over the threshold, so the release reports no excess.
    write_threshold('0);
    hold_level(1'b1, DebounceTicks + 20, 1'b0);
    hold_level(1'b0, DebounceTicks, 1'b0);

    // Random part: the sender idles lightly while the receiver stalls often,
    // then the other way round, then neither holds back.
    run_phase(6, 60, SecondsW'(1), 100);
    run_phase(60, 6, SecondsW'(2), 100);
    run_phase(0, 0, '1, 100);

    quiesce();
    repeat (4) @(negedge clk);
    if (timer_model.mismatches == 0 && timer_model.pending() == 0) begin
      $display("debounced_on_time_timer_alarm verification clean");
    end else begin
      $display("debounced_on_time_timer_alarm verification failed");
    end
    $finish;
  end

endmodule
